[rtl/core/u2u8_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 text capture block.
// ---------------------------------------------------------------------------
package u2u8_pkg;

   // Capacity of the text buffer in bytes.
   localparam int BUFFER_BYTES = 256;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

   // Depth of the queue between front and back end. Must be a power of two.
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

   // Item kinds.
   localparam logic KIND_UNIT  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Encoded UTF-8 bytes of one code unit, first byte in slot 0.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      cnt;
   } u2u8_entry_type;

   // Queue status seen by the two ends.
   typedef struct packed {
      logic full;
      logic empty;
   } u2u8_qstat_type;

endpackage : u2u8_pkg
`default_nettype wire

[rtl/core/u2u8_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// u2u8_front
// Accepts code units, pairs surrogates, encodes the code point to UTF-8 and
// trims the sequence to the remaining buffer capacity.
// ---------------------------------------------------------------------------
module u2u8_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_kind,
   input  wire logic [15:0]              req_code_unit,
   input  wire u2u8_pkg::u2u8_qstat_type qstat,
   output logic                          push,
   output u2u8_pkg::u2u8_entry_type      push_entry
);
   import u2u8_pkg::*;

   logic               pend_valid_ff, pend_valid_in;
   logic [9:0]         pend_bits_ff, pend_bits_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;

   logic               accept;
   logic               is_high, is_low, drop;
   logic [20:0]        cp;
   logic [2:0]         len, n;
   logic [3:0][7:0]    enc;
   logic [COUNT_W-1:0] space;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   assign is_high = (req_code_unit[15:10] == 6'b110110);
   assign is_low  = (req_code_unit[15:10] == 6'b110111);

   always_comb begin
      if (is_low) begin
         if (pend_valid_ff) begin
            cp = {11'(pend_bits_ff) + 11'h040, req_code_unit[9:0]};
         end else begin
            cp = 21'h00FFFD;
         end
      end else begin
         cp = {5'd0, req_code_unit};
      end
   end

   assign drop = (cp < 21'd32) || (cp == 21'd127);

   always_comb begin
      enc = '0;
      if (cp <= 21'h00007F) begin
         len    = 3'd1;
         enc[0] = cp[7:0];
      end else if (cp <= 21'h0007FF) begin
         len    = 3'd2;
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'h00FFFF) begin
         len    = 3'd3;
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
      end else begin
         len    = 3'd4;
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
         enc[3] = {2'b10, cp[5:0]};
      end
   end

   // The count never exceeds the capacity, so the difference cannot wrap.
   assign space = COUNT_W'(BUFFER_BYTES) - bytes_ff;
   assign n     = (space < COUNT_W'(len)) ? space[2:0] : len;

   assign push             = accept && (req_kind == KIND_UNIT) && !is_high && !drop
                             && (n != 3'd0);
   assign push_entry.bytes = enc;
   assign push_entry.cnt   = n;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_bits_in  = pend_bits_ff;
      bytes_in      = bytes_ff;
      if (accept) begin
         if (req_kind == KIND_CLEAR) begin
            bytes_in = '0;
         end else if (is_high) begin
            pend_valid_in = 1'b1;
            pend_bits_in  = req_code_unit[9:0];
         end else begin
            pend_valid_in = 1'b0;
            pend_bits_in  = '0;
            if (!drop) begin
               bytes_in = bytes_ff + COUNT_W'(n);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
         bytes_ff      <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
         bytes_ff      <= bytes_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      bytes_ff <= COUNT_W'(BUFFER_BYTES))
      else $error("byte count above buffer capacity");

   a_push_len: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_entry.cnt != 3'd0) && (push_entry.cnt <= 3'd4))
      else $error("queued sequence length out of range");

endmodule : u2u8_front
`default_nettype wire

[rtl/core/u2u8_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// u2u8_queue
// Short show-ahead queue of encoded sequences between front and back end.
// ---------------------------------------------------------------------------
module u2u8_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire u2u8_pkg::u2u8_entry_type push_entry,
   input  wire logic                     pop,
   output u2u8_pkg::u2u8_entry_type      head,
   output u2u8_pkg::u2u8_qstat_type      qstat
);
   import u2u8_pkg::*;

   u2u8_entry_type      slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;

   assign head        = slots_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("pop from an empty queue");

endmodule : u2u8_queue
`default_nettype wire

[rtl/core/u2u8_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// u2u8_back
// Walks the bytes of the queue head and sends one per cycle, while rsp_stall is
// low, through a registered result stage.
// ---------------------------------------------------------------------------
module u2u8_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire u2u8_pkg::u2u8_entry_type head,
   input  wire u2u8_pkg::u2u8_qstat_type qstat,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last
);
   import u2u8_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load, at_end;

   // The result register takes a new byte when it is empty or being drained.
   assign load   = (!valid_ff || !rsp_stall) && !qstat.empty;
   assign at_end = ({1'b0, idx_ff} + 3'd1) == head.cnt;
   assign pop    = load && at_end;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head.bytes[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule : u2u8_back
`default_nettype wire

[rtl/core/utf16_to_utf8_text_capture.sv]
// The first result byte of an item is registered in the queue, then in the result stage.
// An item is accepted each cycle while the two-entry sequence queue has room.
// Sustained rate is set by the one-byte result port, which sends the UTF-8 bytes
// of an item one at a time; an item that produces none is accepted and sends nothing.
// Synchronous reset clears the pending surrogate, the byte count, the queue pointers
// and the result valid flag and byte index; the result byte itself is not reset.
`default_nettype none
// ---------------------------------------------------------------------------
// utf16_to_utf8_text_capture
// UTF-16 code units in, UTF-8 bytes of a bounded text buffer out.
// ---------------------------------------------------------------------------
module utf16_to_utf8_text_capture (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_code_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);
   import u2u8_pkg::*;

   logic           push, pop;
   u2u8_entry_type push_entry, head;
   u2u8_qstat_type qstat;

   u2u8_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_code_unit(req_code_unit),
      .qstat        (qstat),
      .push         (push),
      .push_entry   (push_entry)
   );

   u2u8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   u2u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last)
   );

endmodule : utf16_to_utf8_text_capture
`default_nettype wire

[verif/utf16_to_utf8_text_capture_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf16_to_utf8_text_capture_tb
// Sends UTF-16 code units and clear items through the request channel and
// checks every UTF-8 byte on the response channel. Expected bytes come from
// a predictor in the testbench that tracks surrogate state and buffer fill.
// The traffic is directed corner cases followed by random sequences.
// ---------------------------------------------------------------------------
module utf16_to_utf8_text_capture_tb;
   import u2u8_pkg::*;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam int          DIRECTED_ITEMS = 25;
   localparam int          TOTAL_ITEMS    = DIRECTED_ITEMS + 105;
   localparam int          QUIET_FROM     = DIRECTED_ITEMS + 85;
   localparam int          DRAIN_AT       = DIRECTED_ITEMS + 45;
   localparam int          WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } utf8_byte_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] unit;
   } text_item_type;

   // Mirrors the transcoder and keeps the bytes it has still to deliver.
   class utf8_byte_checker;
      utf8_byte_type due_bytes[$];
      logic          high_pending;
      logic [9:0]    high_bits;
      int            held;
      int            error_count;

      function new();
         high_pending = 1'b0;
         high_bits    = '0;
         held         = 0;
         error_count  = 0;
      endfunction

      function int outstanding();
         return due_bytes.size();
      endfunction

      function void take_unit(logic kind, logic [15:0] unit);
         logic [20:0] cp;
         logic [7:0]  enc [4];
         int          count;
         int          room;
         if (kind == KIND_CLEAR) begin
            held = 0;
            return;
         end
         if (unit >= HIGH_FIRST && unit <= HIGH_LAST) begin
            high_pending = 1'b1;
            high_bits    = unit[9:0];
            return;
         end
         cp = {5'd0, unit};
         if (unit >= LOW_FIRST && unit <= LOW_LAST) begin
            cp = high_pending ? 21'h10000 + {high_bits, unit[9:0]} : 21'h00FFFD;
         end
         high_pending = 1'b0;
         high_bits    = '0;
         if (cp < 21'd32 || cp == 21'd127) return;
         if (cp <= 21'h7F) begin
            enc[0] = cp[7:0];
            count  = 1;
         end else if (cp <= 21'h7FF) begin
            enc[0] = 8'hC0 | cp[10:6];
            enc[1] = 8'h80 | cp[5:0];
            count  = 2;
         end else if (cp <= 21'hFFFF) begin
            enc[0] = 8'hE0 | cp[15:12];
            enc[1] = 8'h80 | cp[11:6];
            enc[2] = 8'h80 | cp[5:0];
            count  = 3;
         end else begin
            enc[0] = 8'hF0 | cp[20:18];
            enc[1] = 8'h80 | cp[17:12];
            enc[2] = 8'h80 | cp[11:6];
            enc[3] = 8'h80 | cp[5:0];
            count  = 4;
         end
         room = BUFFER_BYTES - held;
         if (count > room) count = room;
         for (int i = 0; i < count; i++) begin
            due_bytes.push_back('{value: enc[i], last: (i == count - 1)});
         end
         held += count;
      endfunction

      function void check_byte(logic [7:0] value, logic last);
         utf8_byte_type want;
         if (due_bytes.size() == 0) begin
            $error("unexpected output byte %h (last %b)", value, last);
            error_count++;
            return;
         end
         want = due_bytes.pop_front();
         if (value !== want.value) begin
            $error("out_byte: expected %h, got %h", want.value, value);
            error_count++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            error_count++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [15:0] req_code_unit;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   utf8_byte_checker sb;
   logic             quiet_tail;
   int               items_sent;
   int               idle_cycles;

   utf16_to_utf8_text_capture uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_code_unit (req_code_unit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic drive_item(logic kind, logic [15:0] unit);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid     <= 1'b0;
         req_kind      <= 1'($urandom_range(0, 1));
         req_code_unit <= 16'($urandom_range(0, 16'hFFFF));
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_code_unit <= unit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_unit(kind, unit);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drive_unit(logic [15:0] unit);
      drive_item(KIND_UNIT, unit);
   endtask

   function automatic logic [15:0] any_bmp_unit();
      case ($urandom_range(0, 2))
         0:       return 16'($urandom_range(32, 126));
         1:       return 16'($urandom_range(16'h0080, 16'h07FF));
         default: return 16'($urandom_range(0, 1) ? $urandom_range(16'h0800, 16'hD7FF)
                                                   : $urandom_range(16'hE000, 16'hFFFF));
      endcase
   endfunction

   task automatic random_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         drive_unit(16'($urandom_range(32, 126)));
      end else if (pick < 22) begin
         drive_unit(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (pick < 40) begin
         drive_unit(16'($urandom_range(0, 1) ? $urandom_range(16'h0800, 16'hD7FF)
                                             : $urandom_range(16'hE000, 16'hFFFF)));
      end else if (pick < 72) begin
         drive_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
         drive_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (pick < 77) begin
         drive_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (pick < 82) begin
         // The orphaned high surrogate must be dropped silently.
         drive_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
         drive_unit(any_bmp_unit());
      end else if (pick < 86) begin
         drive_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
         drive_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
         drive_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (pick < 91) begin
         drive_unit($urandom_range(0, 4) == 0 ? 16'd127 : 16'($urandom_range(0, 31)));
      end else begin
         drive_unit(16'($urandom_range(0, 16'hFFFF)));
      end
   endtask

   // Response-side back-pressure in random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         int pick;
         pick = $urandom_range(0, 9);
         if (quiet_tail || pick > 2) begin
            rsp_stall <= 1'b0;
            repeat (pick == 9 ? $urandom_range(20, 60) : $urandom_range(1, 12))
               @(negedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_byte(rsp_out_byte, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      text_item_type corner [DIRECTED_ITEMS];
      logic          drained;
      corner = '{
         '{KIND_UNIT, 16'h0041}, '{KIND_UNIT, 16'h0020}, '{KIND_UNIT, 16'h001F},
         '{KIND_UNIT, 16'h0000}, '{KIND_UNIT, 16'h007F}, '{KIND_UNIT, 16'h0080},
         '{KIND_UNIT, 16'h07FF}, '{KIND_UNIT, 16'h0800}, '{KIND_UNIT, 16'hFFFF},
         '{KIND_UNIT, 16'hD800}, '{KIND_UNIT, 16'hDC00},
         '{KIND_UNIT, 16'hDBFF}, '{KIND_UNIT, 16'hDFFF},
         '{KIND_UNIT, 16'hDC00},
         '{KIND_UNIT, 16'hD801}, '{KIND_UNIT, 16'hDBFE}, '{KIND_UNIT, 16'hDC05},
         '{KIND_UNIT, 16'hD900}, '{KIND_UNIT, 16'h0042},
         '{KIND_UNIT, 16'hDA00}, '{KIND_UNIT, 16'h0001}, '{KIND_UNIT, 16'hDC00},
         // A clear keeps the pending high surrogate alive.
         '{KIND_UNIT, 16'hD805}, '{KIND_CLEAR, 16'hFFFF}, '{KIND_UNIT, 16'hDC01}
      };
      sb            = new();
      quiet_tail    = 1'b0;
      items_sent    = 0;
      drained       = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_UNIT;
      req_code_unit = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner[i]) drive_item(corner[i].kind, corner[i].unit);

      while (items_sent < TOTAL_ITEMS) begin
         quiet_tail = (items_sent >= QUIET_FROM);
         if (!drained && items_sent >= DRAIN_AT) begin
            // Let the block run dry before feeding it again.
            drained = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (sb.outstanding() != 0) @(negedge clock);
         end
         if (sb.held == BUFFER_BYTES ? $urandom_range(0, 2) == 0
                                     : $urandom_range(0, 99) == 0) begin
            drive_item(KIND_CLEAR, 16'($urandom_range(0, 16'hFFFF)));
         end else begin
            random_sequence();
         end
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
